@@ hw/rtl/dbt_pkg.sv @@
`default_nettype none

package dbt_pkg;

    localparam int LINES    = 64;
    localparam int LINE_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int TIME_W   = 64;
    localparam int LEVELS_W = 64;
    localparam int IDX_W    = 6;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT = 2'd2;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 64'd2_000_000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 1'd1;

    typedef struct packed {
        logic [LEVELS_W-1:0] line_levels;
        logic [TIME_W-1:0]   time_ns;
        logic                rising;
        logic [IDX_W-1:0]    line_index;
        logic [OP_W-1:0]     operation;
    } item_t;

    typedef struct packed {
        logic          debounce_active;
        logic          report;
        logic [63:0]   debounced_lines;
        logic [63:0]   line_values;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0] period_ns;
        logic [LINES-1:0]  enable_mask;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/edge_timestamp_debouncer_unit.sv @@
// Channel   Direction  Item
// s_        in         one edge event, tick or init (operation in s_tuser)
// m_        out        one line state snapshot per input item
// cfg_      in         register write, no wait, no read-back
//
// Init, unused operations and edges on lines past LINES - 1 go from idle
// straight to done; an edge passes through the edge state, and a tick walks
// the first-edge time memory in the scan state one line a cycle through its
// single read port. The result waits in an output register, so a stall on
// m_ holds only the following item's done step. Reset clears line flags.

`default_nettype none

module edge_timestamp_debouncer_unit
    import dbt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_wdata,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // line_index[5:0], rising[6], time_ns[70:7], line_levels[134:71], zero pad
    input  wire logic [135:0]         s_tdata,
    // operation[1:0]
    input  wire logic [1:0]           s_tuser,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // line_values[63:0], debounced_lines[127:64], report[128],
    // debounce_active[129], zero pad
    output      logic [135:0]         m_tdata
);

    logic [TIME_W-1:0] period_reg;
    logic [LINES-1:0]  mask_reg;
    cfg_t              cfg;
    item_t             in_item;
    result_t           result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            mask_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_wdata;
                CFG_MASK:   mask_reg   <= cfg_wdata[LINES-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.period_ns   = period_reg;
    assign cfg.enable_mask = mask_reg;

    assign in_item.operation   = s_tuser;
    assign in_item.line_index  = s_tdata[5:0];
    assign in_item.rising      = s_tdata[6];
    assign in_item.time_ns     = s_tdata[70:7];
    assign in_item.line_levels = s_tdata[134:71];

    dbt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {6'd0, result.debounce_active, result.report,
                      result.debounced_lines, result.line_values};

endmodule

`default_nettype wire

@@ hw/rtl/dbt_ram.sv @@
`default_nettype none

module dbt_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dbt_ctrl.sv @@
`default_nettype none

module dbt_ctrl
    import dbt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_t    cfg,
    input  wire logic    in_valid,
    output      logic    in_ready,
    input  wire item_t   in_item,
    output      logic    out_valid,
    input  wire logic    out_ready,
    output      result_t out_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [LINE_W-1:0] cnt_reg, cnt_next;
    logic [LINES-1:0]  value_reg, value_next;
    logic [LINES-1:0]  deb_reg, deb_next;
    logic [LINES-1:0]  changed_reg, changed_next;
    logic              report_reg, report_next;
    logic              active_reg, active_next;
    logic              m_valid_reg, m_valid_next;
    result_t           out_reg, out_next;

    logic              ram_rd_en;
    logic [LINE_W-1:0] ram_rd_addr;
    logic              ram_wr_en;
    logic [TIME_W-1:0] ram_rd_data;

    logic [LINE_W-1:0] edge_line;
    logic [LINE_W-1:0] in_line;
    logic [TIME_W-1:0] first_time;
    logic              expired;

    dbt_ram #(
        .DEPTH  (LINES),
        .WIDTH  (TIME_W),
        .ADDR_W (LINE_W)
    ) u_time_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (edge_line),
        .wr_data (item_reg.time_ns),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign edge_line = item_reg.line_index[LINE_W-1:0];
    assign in_line   = in_item.line_index[LINE_W-1:0];

    always_comb begin
        if (state_reg == ST_EDGE && !changed_reg[edge_line]) begin
            first_time = item_reg.time_ns;
        end else begin
            first_time = ram_rd_data;
        end
        expired = (item_reg.time_ns - first_time) > cfg.period_ns;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        cnt_next     = cnt_reg;
        value_next   = value_reg;
        deb_next     = deb_reg;
        changed_next = changed_reg;
        report_next  = report_reg;
        active_next  = active_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !out_ready;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = cnt_reg;
        ram_wr_en    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next   = in_item;
                    report_next = 1'b0;
                    active_next = 1'b0;
                    state_next  = ST_DONE;
                    unique case (in_item.operation)
                        OP_EDGE: begin
                            if ({1'b0, in_item.line_index} < (IDX_W + 1)'(LINES)) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = in_line;
                                state_next  = ST_EDGE;
                            end
                        end
                        OP_TICK: begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            cnt_next    = '0;
                            state_next  = ST_SCAN;
                        end
                        OP_INIT: begin
                            value_next   = in_item.line_levels[LINES-1:0];
                            deb_next     = '0;
                            changed_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EDGE: begin
                ram_wr_en                = !changed_reg[edge_line];
                changed_next[edge_line]  = 1'b1;
                value_next[edge_line]    = item_reg.rising;
                if (cfg.enable_mask[edge_line] && !deb_reg[edge_line]) begin
                    if (expired) begin
                        deb_next[edge_line] = 1'b1;
                    end else begin
                        active_next = 1'b1;
                    end
                end
                report_next = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN: begin
                if (changed_reg[cnt_reg] && cfg.enable_mask[cnt_reg] && !deb_reg[cnt_reg]) begin
                    if (expired) begin
                        deb_next[cnt_reg]   = 1'b1;
                        value_next[cnt_reg] = item_reg.line_levels[cnt_reg];
                        report_next         = 1'b1;
                    end else begin
                        active_next = 1'b1;
                    end
                end
                if (cnt_reg == LINE_W'(LINES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next    = cnt_reg + 1'b1;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || out_ready) begin
                    out_next.line_values     = 64'(value_reg);
                    out_next.debounced_lines = 64'(deb_reg);
                    out_next.report          = report_reg;
                    out_next.debounce_active = active_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            value_reg   <= '0;
            deb_reg     <= '0;
            changed_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            value_reg   <= value_next;
            deb_reg     <= deb_next;
            changed_reg <= changed_next;
        end
        item_reg   <= item_next;
        cnt_reg    <= cnt_next;
        report_reg <= report_next;
        active_reg <= active_next;
        out_reg    <= out_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = m_valid_reg;
    assign out_result = out_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_edge_timestamp_debouncer_unit.sv @@
`default_nettype none

module tb_edge_timestamp_debouncer_unit;
    import dbt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LONG_HOLD     = 400;
    localparam int LONG_HOLD_AT  = 330;
    localparam int QUIET_LIMIT   = 4000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 108;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [63:0]          cfg_val;
        item_t                it;
        bit                   typed;
        result_t              want;
    } step_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [135:0]         s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [135:0]         m_tdata;

    logic [63:0]      shadow_period = PERIOD_RESET;
    logic [63:0]      shadow_mask = '0;
    logic [LINES-1:0] shadow_value = '0;
    logic [LINES-1:0] shadow_deb = '0;
    logic [LINES-1:0] shadow_changed = '0;
    logic [63:0]      shadow_first [LINES];

    result_t snapshot_q [$];
    step_t   directed_q [$];
    int      snapshots_seen = 0;
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      settings_used = 0;
    int      quiet_cycles = 0;
    bit      long_hold_done = 1'b0;

    edge_timestamp_debouncer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic result_t make_snapshot(logic [63:0] values, logic [63:0] deb,
                                              logic rep, logic act);
        result_t r;
        r.line_values     = values;
        r.debounced_lines = deb;
        r.report          = rep;
        r.debounce_active = act;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic predict_snapshot(input item_t it, output result_t snap);
        logic [63:0] elapsed;
        logic        rep;
        logic        act;
        int          i;
        rep = 1'b0;
        act = 1'b0;
        case (it.operation)
            OP_EDGE: begin
                i = it.line_index;
                if (i < LINES) begin
                    if (!shadow_changed[i]) shadow_first[i] = it.time_ns;
                    shadow_changed[i] = 1'b1;
                    shadow_value[i] = it.rising;
                    if (shadow_mask[i] && !shadow_deb[i]) begin
                        elapsed = it.time_ns - shadow_first[i];
                        if (elapsed > shadow_period) shadow_deb[i] = 1'b1;
                        else act = 1'b1;
                    end
                    rep = 1'b1;
                end
            end
            OP_TICK: begin
                for (int n = 0; n < LINES; n++) begin
                    if (shadow_changed[n] && shadow_mask[n] && !shadow_deb[n]) begin
                        elapsed = it.time_ns - shadow_first[n];
                        if (elapsed > shadow_period) begin
                            shadow_deb[n] = 1'b1;
                            shadow_value[n] = it.line_levels[n];
                            rep = 1'b1;
                        end else begin
                            act = 1'b1;
                        end
                    end
                end
            end
            OP_INIT: begin
                shadow_deb = '0;
                shadow_changed = '0;
                for (int n = 0; n < LINES; n++) shadow_first[n] = '0;
                shadow_value = it.line_levels[LINES-1:0];
            end
            default: begin
            end
        endcase
        snap = make_snapshot(64'(shadow_value), 64'(shadow_deb), rep, act);
    endtask

    task automatic add_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic rise,
                            logic [63:0] t, logic [63:0] lv, bit typed, result_t want);
        step_t s;
        s.is_cfg = 1'b0;
        s.cfg_idx = '0;
        s.cfg_val = '0;
        s.it.operation = op;
        s.it.line_index = idx;
        s.it.rising = rise;
        s.it.time_ns = t;
        s.it.line_levels = lv;
        s.typed = typed;
        s.want = want;
        directed_q.push_back(s);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        step_t s;
        s.is_cfg = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = val;
        s.it = '0;
        s.typed = 1'b0;
        s.want = '0;
        directed_q.push_back(s);
    endtask

    task automatic send_item(input item_t it, input bit typed, input result_t want,
                             input int gap);
        result_t predicted;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.line_levels, it.time_ns, it.rising, it.line_index};
        s_tuser  <= it.operation;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_snapshot(it, predicted);
        snapshot_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (snapshot_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_PERIOD) shadow_period = val;
        else shadow_mask = val;
        settings_used++;
    endtask

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on item %0d, %s: expected %h, got %h",
                     snapshots_seen, what, want, got);
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[129:0]);
            snapshots_seen++;
            if (snapshot_q.size() == 0) begin
                report_mismatch("unexpected item", '0, got.line_values);
            end else begin
                want = snapshot_q.pop_front();
                if (got.line_values !== want.line_values)
                    report_mismatch("line_values", want.line_values, got.line_values);
                if (got.debounced_lines !== want.debounced_lines)
                    report_mismatch("debounced_lines", want.debounced_lines,
                                    got.debounced_lines);
                if (got.report !== want.report)
                    report_mismatch("report", 64'(want.report), 64'(got.report));
                if (got.debounce_active !== want.debounce_active)
                    report_mismatch("debounce_active", 64'(want.debounce_active),
                                    64'(got.debounce_active));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no handshake for %0d cycles, %0d items outstanding",
                         quiet_cycles, snapshot_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : output_side
        int hi;
        int lo;
        wait (aresetn === 1'b1);
        forever begin
            if (!long_hold_done && snapshots_seen >= LONG_HOLD_AT) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                long_hold_done = 1'b1;
            end
            hi = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            lo = pick_gap();
            @(negedge aclk);
            m_tready <= 1'b1;
            repeat (hi - 1) @(negedge aclk);
            if (lo > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (lo - 1) @(negedge aclk);
            end
        end
    end

    initial begin : input_side
        item_t       it;
        int          counted;
        int          r;
        int unsigned step_max;
        logic [63:0] clock_ns;
        bit          no_gaps;

        for (int n = 0; n < LINES; n++) shadow_first[n] = '0;

        add_item(OP_UNUSED, 6'd63, 1'b1, '1, '1, 1'b1, make_snapshot('0, '0, 1'b0, 1'b0));
        add_item(OP_INIT, 6'd0, 1'b0, '0, '1, 1'b1, make_snapshot('1, '0, 1'b0, 1'b0));
        add_item(OP_EDGE, 6'd0, 1'b0, '0, '0, 1'b1,
                 make_snapshot(64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b1, 1'b0));
        add_item(OP_TICK, 6'd0, 1'b0, '1, '0, 1'b0, '0);
        add_item(OP_INIT, 6'd0, 1'b0, '0, '0, 1'b1, make_snapshot('0, '0, 1'b0, 1'b0));
        add_cfg(CFG_MASK, '1);
        add_cfg(CFG_PERIOD, 64'd100);
        add_item(OP_EDGE, 6'd5, 1'b1, 64'd0, '0, 1'b0, '0);
        add_item(OP_EDGE, 6'd5, 1'b0, 64'd100, '0, 1'b0, '0);
        add_item(OP_TICK, 6'd0, 1'b0, 64'd100, '1, 1'b0, '0);
        add_item(OP_TICK, 6'd0, 1'b0, 64'd101, '1, 1'b0, '0);
        add_item(OP_EDGE, 6'd5, 1'b0, 64'd5000, '0, 1'b0, '0);
        add_item(OP_EDGE, 6'd63, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, '0, 1'b0, '0);
        add_item(OP_EDGE, 6'd63, 1'b0, 64'h50, '0, 1'b0, '0);
        add_item(OP_EDGE, 6'd63, 1'b1, 64'h55, '0, 1'b0, '0);
        add_item(OP_EDGE, 6'd10, 1'b1, 64'd1000, '0, 1'b0, '0);
        add_cfg(CFG_MASK, 64'hAAAA_AAAA_AAAA_AAAA);
        add_item(OP_TICK, 6'd0, 1'b0, 64'd5000, '0, 1'b0, '0);
        add_cfg(CFG_MASK, '1);
        add_item(OP_TICK, 6'd0, 1'b0, 64'd1050, '0, 1'b0, '0);
        add_cfg(CFG_PERIOD, '0);
        add_item(OP_EDGE, 6'd20, 1'b1, 64'd7, '0, 1'b0, '0);
        add_item(OP_TICK, 6'd0, 1'b0, 64'd7, '1, 1'b0, '0);
        add_item(OP_TICK, 6'd0, 1'b0, 64'd8, '1, 1'b0, '0);
        add_cfg(CFG_PERIOD, '1);
        add_item(OP_INIT, 6'd0, 1'b0, '0, 64'h0123_4567_89AB_CDEF, 1'b1,
                 make_snapshot(64'h0123_4567_89AB_CDEF, '0, 1'b0, 1'b0));
        add_item(OP_EDGE, 6'd1, 1'b1, 64'h8000_0000_0000_0000, '0, 1'b0, '0);
        add_item(OP_TICK, 6'd0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, '1, 1'b0, '0);
        add_item(OP_EDGE, 6'd42, 1'b1, 64'd3, '0, 1'b0, '0);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_q[k]) begin
            if (directed_q[k].is_cfg) begin
                go_idle();
                write_reg(directed_q[k].cfg_idx, directed_q[k].cfg_val);
            end else begin
                send_item(directed_q[k].it, directed_q[k].typed, directed_q[k].want,
                          pick_gap());
            end
        end

        clock_ns = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            go_idle();
            case (p)
                0: begin
                    write_reg(CFG_PERIOD, PERIOD_RESET);
                    write_reg(CFG_MASK, '1);
                end
                1: begin
                    write_reg(CFG_PERIOD, '0);
                    write_reg(CFG_MASK, {$urandom, $urandom});
                end
                2: begin
                    write_reg(CFG_PERIOD, '1);
                    write_reg(CFG_MASK, '1);
                end
                3: begin
                    write_reg(CFG_PERIOD, 64'($urandom_range(1, 500)));
                    write_reg(CFG_MASK, '0);
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) write_reg(CFG_PERIOD, {$urandom, $urandom});
                    else write_reg(CFG_PERIOD, 64'($urandom_range(0, 5000)));
                    if ($urandom_range(0, 1) == 0) write_reg(CFG_MASK, '1);
                    else write_reg(CFG_MASK, {$urandom, $urandom});
                end
            endcase
            if (shadow_period < 64'd3_000_000_000) step_max = 32'(shadow_period / 3 + 3);
            else step_max = 32'h7FFF_FFFF;
            no_gaps = ($urandom_range(0, 3) == 0);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 85) clock_ns = clock_ns + 64'($urandom_range(0, step_max));
                else if (r < 95) clock_ns = {$urandom, $urandom};
                else clock_ns = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 255));
                r = $urandom_range(0, 99);
                if (r < 58) it.operation = OP_EDGE;
                else if (r < 83) it.operation = OP_TICK;
                else if (r < 92) it.operation = OP_INIT;
                else it.operation = OP_UNUSED;
                if ($urandom_range(0, 9) < 6) it.line_index = IDX_W'($urandom_range(0, 7));
                else it.line_index = IDX_W'($urandom_range(0, 63));
                it.rising = 1'($urandom_range(0, 1));
                it.time_ns = clock_ns;
                it.line_levels = {$urandom, $urandom};
                send_item(it, 1'b0, '0, no_gaps ? 0 : pick_gap());
                if (it.operation != OP_UNUSED) counted++;
            end
        end

        go_idle();
        repeat (LINES + 16) @(posedge aclk);
        mismatch_count += snapshot_q.size();

        $display("sent %0d edge, tick, init and unused items across %0d register writes",
                 items_sent, settings_used);
        $display("checked %0d line-state items, %0d mismatches, long output stall %0s",
                 snapshots_seen, mismatch_count, long_hold_done ? "seen" : "missed");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
